// ----- rtl/bnfa_pkg.sv -----
// Shared constants, types and codes of the bitmap next-fit allocator.
package bnfa_pkg;

  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned MAP_WORDS   = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;

  localparam int unsigned IDX_W   = $clog2(MAX_ENTRIES);
  localparam int unsigned TOT_W   = IDX_W + 1;
  localparam int unsigned BIT_W   = $clog2(WORD_BITS);
  localparam int unsigned WADDR_W = IDX_W - BIT_W;
  localparam int unsigned CNT_W   = $clog2(MAP_WORDS + 3);
  localparam int unsigned DIV_W   = $clog2(IDX_W + 1);

  localparam int unsigned MODE_W    = 16;
  localparam int unsigned PERM_BITS = 9;
  localparam int unsigned TYPE_W    = MODE_W - PERM_BITS;
  localparam int unsigned ST_W      = 2;

  // Type field (mode bits above the permission bits)
  localparam logic [TYPE_W-1:0] TYPE_REG = TYPE_W'(16'h8000 >> PERM_BITS);
  localparam logic [TYPE_W-1:0] TYPE_DIR = TYPE_W'(16'h4000 >> PERM_BITS);
  localparam logic [TYPE_W-1:0] TYPE_LNK = TYPE_W'(16'hA000 >> PERM_BITS);

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

  // Configuration port
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_ENTRY_TOTAL = '0;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [TOT_W-1:0]     tot_t;
  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WADDR_W-1:0]   waddr_t;
  typedef logic [BIT_W-1:0]     bitpos_t;

  typedef struct packed {
    logic   rd_en;
    waddr_t rd_addr;
    logic   wr_en;
    waddr_t wr_addr;
    word_t  wr_data;
  } map_ctl_t;

  typedef struct packed {
    logic wr;
    tot_t total;
  } cfg_t;

endpackage

// ----- rtl/bnfa_if.sv -----
// Request and result channel interfaces of the bitmap next-fit allocator.
interface bnfa_req_if;
  import bnfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] entry_mode;
  modport source (output valid, output entry_mode, input ready);
  modport sink   (input valid, input entry_mode, output ready);
endinterface

interface bnfa_rsp_if;
  import bnfa_pkg::*;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [IDX_W-1:0] entry_index;
  logic [TOT_W-1:0] free_left;
  modport source (output valid, output status, output entry_index, output free_left,
                  input ready);
  modport sink   (input valid, input status, input entry_index, input free_left,
                  output ready);
endinterface

// ----- rtl/bitmap_next_fit_allocator_core.sv -----
// Bitmap next-fit entry allocator: each request carries a mode word whose type
// bits (above the nine permission bits) must be regular file, directory or
// symbolic link, else the request returns status 1. When the free count is
// zero, or no clear bit lies below entry_total, it returns status 2, clears the
// free count and sets the search pointer to 1 (0 when the total is 1).
// Otherwise the used bitmap is scanned cyclically from the search pointer, one
// 32-bit word per cycle through a single find-first-zero unit on a registered
// memory read; the first clear bit is set, the free count drops by one and the
// pointer moves to it. A scan examines at most one word more than the map holds.
// When entry_total has been lowered to or below the current pointer, a
// remainder pass through the compare-subtract unit comes first. The block
// takes one request at a time. Writing entry_total reloads the free count but
// leaves the bitmap as it is; write it only while no request is in flight.
module bitmap_next_fit_allocator_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bnfa_req_if.sink                     req_i,
  bnfa_rsp_if.source                   rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bnfa_pkg::PADDR_W-1:0] paddr,
  input  logic [bnfa_pkg::PDATA_W-1:0] pwdata,
  output logic [bnfa_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import bnfa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  cfg_t     cfg;
  map_ctl_t map_ctl;
  word_t    rdata;

  // allocator state
  idx_t ptr_q, ptr_d;
  tot_t free_q, free_d;
  tot_t total;

  // scan bookkeeping
  idx_t             start_q, start_d;
  waddr_t           rd_word_q, rd_word_d;
  logic [CNT_W-1:0] issued_q, issued_d;
  logic             pend_q, pend_d;
  logic             pend_first_q, pend_first_d;
  logic             pend_last_q, pend_last_d;
  waddr_t           pend_word_q, pend_word_d;

  // pending result
  logic [ST_W-1:0] res_st_q, res_st_d;
  idx_t            res_idx_q, res_idx_d;
  tot_t            res_free_q, res_free_d;

  // result register
  logic            out_vld_q, out_vld_d;
  logic [ST_W-1:0] out_st_q;
  idx_t            out_idx_q;
  tot_t            out_free_q;
  logic            out_load;

  logic rem_start, rem_done;
  idx_t rem;

  tot_t             tm1;
  waddr_t           last_word;
  bitpos_t          last_bits;
  logic [CNT_W-1:0] visits;
  word_t            lim_mask, first_mask, cand;
  logic             ffz_found;
  bitpos_t          ffz_pos;
  logic             type_ok;
  logic             req_fire;
  idx_t             full_ptr;

  bnfa_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bnfa_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (map_ctl),
    .rdata_o (rdata)
  );

  bnfa_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (ptr_q),
    .divisor_i  (total),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  bnfa_ffz u_ffz (
    .cand_i  (cand),
    .found_o (ffz_found),
    .pos_o   (ffz_pos)
  );

  // Current total; the register output equals cfg.total outside write cycles.
  assign total = cfg.total;

  assign tm1       = total - TOT_W'(1);
  assign last_word = tm1[IDX_W-1:BIT_W];
  assign last_bits = tm1[BIT_W-1:0];
  // one extra visit returns to the start word for the bits below the start
  assign visits    = CNT_W'(last_word) + CNT_W'(2);
  assign full_ptr  = (total == TOT_W'(1)) ? '0 : IDX_W'(1);

  // eligible bits: below entry_total, and at or above the start on first visit
  assign lim_mask   = (pend_word_q == last_word) ?
                      (word_t'('1) >> (BIT_W'(WORD_BITS - 1) - last_bits)) : word_t'('1);
  assign first_mask = pend_first_q ? (word_t'('1) << start_q[BIT_W-1:0]) : word_t'('1);
  assign cand       = ~rdata & lim_mask & first_mask;

  assign type_ok = (req_i.entry_mode[MODE_W-1:PERM_BITS] == TYPE_REG) ||
                   (req_i.entry_mode[MODE_W-1:PERM_BITS] == TYPE_DIR) ||
                   (req_i.entry_mode[MODE_W-1:PERM_BITS] == TYPE_LNK);

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    free_d       = free_q;
    start_d      = start_q;
    rd_word_d    = rd_word_q;
    issued_d     = issued_q;
    pend_d       = 1'b0;
    pend_first_d = pend_first_q;
    pend_last_d  = pend_last_q;
    pend_word_d  = pend_word_q;
    res_st_d     = res_st_q;
    res_idx_d    = res_idx_q;
    res_free_d   = res_free_q;
    rem_start    = 1'b0;
    out_load     = 1'b0;

    map_ctl.rd_en   = 1'b0;
    map_ctl.rd_addr = rd_word_q;
    map_ctl.wr_en   = 1'b0;
    map_ctl.wr_addr = pend_word_q;
    map_ctl.wr_data = rdata | (word_t'(1) << ffz_pos);

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          if (!type_ok) begin
            res_st_d   = ST_BAD_TYPE;
            res_idx_d  = '0;
            res_free_d = free_q;
            state_d    = S_DONE;
          end else if (free_q == '0) begin
            ptr_d      = full_ptr;
            res_st_d   = ST_FULL;
            res_idx_d  = '0;
            res_free_d = '0;
            state_d    = S_DONE;
          end else if ({1'b0, ptr_q} < total) begin
            start_d   = ptr_q;
            rd_word_d = ptr_q[IDX_W-1:BIT_W];
            issued_d  = '0;
            state_d   = S_SCAN;
          end else begin
            // pointer lies past a lowered total: reduce it first
            rem_start = 1'b1;
            state_d   = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (rem_done) begin
          start_d   = rem;
          rd_word_d = rem[IDX_W-1:BIT_W];
          issued_d  = '0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue the next word while evaluating the one read last cycle
        if (issued_q != visits) begin
          map_ctl.rd_en = 1'b1;
          rd_word_d     = (rd_word_q == last_word) ? '0 : rd_word_q + WADDR_W'(1);
          issued_d      = issued_q + CNT_W'(1);
          pend_d        = 1'b1;
          pend_first_d  = (issued_q == '0);
          pend_last_d   = (issued_q == visits - CNT_W'(1));
          pend_word_d   = rd_word_q;
        end
        if (pend_q) begin
          if (ffz_found) begin
            map_ctl.wr_en = 1'b1;
            ptr_d         = {pend_word_q, ffz_pos};
            free_d        = free_q - TOT_W'(1);
            res_st_d      = ST_OK;
            res_idx_d     = {pend_word_q, ffz_pos};
            res_free_d    = free_q - TOT_W'(1);
            pend_d        = 1'b0;
            state_d       = S_DONE;
          end else if (pend_last_q) begin
            // count disagreed with the map: drop the count
            ptr_d      = full_ptr;
            free_d     = '0;
            res_st_d   = ST_FULL;
            res_idx_d  = '0;
            res_free_d = '0;
            pend_d     = 1'b0;
            state_d    = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg.wr) begin
      free_d = cfg.total;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ptr_q     <= '0;
      free_q    <= TOT_W'(MAX_ENTRIES);
      issued_q  <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      free_q    <= free_d;
      issued_q  <= issued_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q      <= start_d;
    rd_word_q    <= rd_word_d;
    pend_first_q <= pend_first_d;
    pend_last_q  <= pend_last_d;
    pend_word_q  <= pend_word_d;
    res_st_q     <= res_st_d;
    res_idx_q    <= res_idx_d;
    res_free_q   <= res_free_d;
    if (out_load) begin
      out_st_q   <= res_st_q;
      out_idx_q  <= res_idx_q;
      out_free_q <= res_free_q;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.status      = out_st_q;
  assign rsp_o.entry_index = out_idx_q;
  assign rsp_o.free_left   = out_free_q;

`ifndef NO_ASSERTIONS
  // refused requests never carry an index
  a_refused_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != ST_OK) |-> rsp_o.entry_index == '0)
    else $error("refused request carries a nonzero index");

  // the free count never exceeds the configured total (the total moves ahead
  // of the count during a write cycle)
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg.wr |-> free_q <= total)
    else $error("free count exceeds entry total");

  // a total write reloads the free count
  a_cfg_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.wr |=> free_q == $past(cfg.total))
    else $error("free count not reloaded on total write");

  // an allocation leaves fewer free entries than the total
  a_ok_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status == ST_OK) |-> rsp_o.free_left < total)
    else $error("allocation reports too many free entries");
`endif

endmodule

// ----- rtl/bnfa_apb.sv -----
// APB register file holding the entry total.
module bnfa_apb (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bnfa_pkg::PADDR_W-1:0] paddr,
  input  logic [bnfa_pkg::PDATA_W-1:0] pwdata,
  output logic [bnfa_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output bnfa_pkg::cfg_t              cfg_o
);
  import bnfa_pkg::*;

  logic                 wr_hit;
  logic [REG_IDX_W-1:0] reg_idx;
  tot_t                 wr_val;
  tot_t                 total_d, total_q;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_hit  = psel && penable && pwrite && (reg_idx == REG_ENTRY_TOTAL);
  assign wr_val  = pwdata[TOT_W-1:0];

  // clamp to 1..MAX_ENTRIES
  always_comb begin
    total_d = total_q;
    if (wr_hit) begin
      if (wr_val == '0) begin
        total_d = TOT_W'(1);
      end else if (wr_val > TOT_W'(MAX_ENTRIES)) begin
        total_d = TOT_W'(MAX_ENTRIES);
      end else begin
        total_d = wr_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOT_W'(MAX_ENTRIES);
    end else begin
      total_q <= total_d;
    end
  end

  assign prdata    = (reg_idx == REG_ENTRY_TOTAL) ? PDATA_W'(total_q) : '0;
  assign cfg_o.wr    = wr_hit;
  assign cfg_o.total = total_d;

endmodule

// ----- rtl/bnfa_map.sv -----
// Used-entry bitmap memory, one word read and one word written per cycle.
module bnfa_map (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bnfa_pkg::map_ctl_t ctl_i,
  output bnfa_pkg::word_t    rdata_o
);
  import bnfa_pkg::*;

  word_t                mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_q;
  word_t                rdata_q;
  logic                 rvld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[ctl_i.wr_addr] <= ctl_i.wr_data;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[ctl_i.rd_addr];
    end
  end

  // A word never written reads as all clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        vld_q[ctl_i.wr_addr] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rvld_q <= vld_q[ctl_i.rd_addr];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ----- rtl/bnfa_rem.sv -----
// Restoring remainder unit: one compare-subtract per cycle.
module bnfa_rem (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  bnfa_pkg::idx_t dividend_i,
  input  bnfa_pkg::tot_t divisor_i,
  output logic           done_o,
  output bnfa_pkg::idx_t rem_o
);
  import bnfa_pkg::*;

  logic [DIV_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  idx_t             rem_q, rem_d;
  idx_t             sh_q, sh_d;
  tot_t             trial;

  assign trial = {rem_q, sh_q[IDX_W-1]};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    if (start_i) begin
      cnt_d  = DIV_W'(IDX_W);
      busy_d = 1'b1;
      rem_d  = '0;
      sh_d   = dividend_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        // remainder is final: drop busy after the done cycle
        busy_d = 1'b0;
      end else begin
        // bring down one bit, subtract where it fits
        if (trial >= divisor_i) begin
          rem_d = IDX_W'(trial - divisor_i);
        end else begin
          rem_d = trial[IDX_W-1:0];
        end
        sh_d  = {sh_q[IDX_W-2:0], 1'b0};
        cnt_d = cnt_q - DIV_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign rem_o  = rem_q;

endmodule

// ----- rtl/bnfa_ffz.sv -----
// Lowest set bit of a candidate word (the clear, eligible bitmap bits).
module bnfa_ffz (
  input  bnfa_pkg::word_t   cand_i,
  output logic              found_o,
  output bnfa_pkg::bitpos_t pos_o
);
  import bnfa_pkg::*;

  always_comb begin
    pos_o = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand_i[i]) begin
        pos_o = BIT_W'(i);
      end
    end
  end

  assign found_o = |cand_i;

endmodule

// ----- sim/tb_bitmap_next_fit_allocator_core.sv -----
// Self-checking testbench of the bitmap next-fit allocator core.
module tb_bitmap_next_fit_allocator_core;
  import bnfa_pkg::*;

  // Run shape
  localparam int unsigned RANDOM_PHASES   = 12;
  localparam int unsigned ITEMS_PER_PHASE = 102;
  localparam int unsigned DRAIN_AT        = 700;   // sender waits for a full drain here
  localparam int unsigned LONG_HOLD_AT    = 400;   // receiver goes deaf here
  localparam int unsigned LONG_HOLD_LEN   = 300;
  localparam int unsigned TAIL_CYCLES     = 60;    // longest allocation plus remainder pass
  localparam int unsigned QUIET_LIMIT     = 4000;

  typedef struct packed {
    logic [ST_W-1:0] status;
    idx_t            entry_index;
    tot_t            free_left;
  } alloc_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  bnfa_req_if req_if ();
  bnfa_rsp_if rsp_if ();

  bitmap_next_fit_allocator_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the allocator state: used bitmap, next-fit pointer, free count and
  // the effective (clamped) entry_total.
  bit          used_bits [MAX_ENTRIES];
  int unsigned scan_ptr  = 0;
  int unsigned free_cnt  = MAX_ENTRIES;
  int unsigned total_cnt = MAX_ENTRIES;

  logic [MODE_W-1:0] queued_modes [$];      // requests not yet offered
  alloc_result_t     predicted_allocs [$];  // results owed by the block, oldest first

  int unsigned reqs_accepted   = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_cnt    = 0;
  int unsigned allocs_seen     = 0;
  int unsigned bad_type_seen   = 0;
  int unsigned full_seen       = 0;
  int unsigned cfg_writes      = 0;
  int unsigned send_gap;
  int unsigned rsp_stall;
  int unsigned quiet_cycles    = 0;
  bit          long_hold_done  = 1'b0;
  logic        req_offer;
  logic        rsp_accept;
  alloc_result_t head_alloc;

  // Corner mode words: each valid type, regular files at both permission extremes,
  // and every type bit set on its own or in an illegal mix.
  logic [MODE_W-1:0] corner_modes [16] = '{
    {TYPE_REG, 9'h000}, {TYPE_REG, 9'h1FF}, {TYPE_DIR, 9'h0A5}, {TYPE_LNK, 9'h15A},
    16'hFFFF, 16'h01FF, 16'h0200, 16'h0400, 16'h0800, 16'h1000, 16'h2000,
    16'hC000, 16'hE000, 16'h8200, 16'h6000, {TYPE_DIR, 9'h1FF}
  };

  // Totals for the random phases: low and high extremes, out-of-range values that
  // clamp, and values below the pointer so the scan starts at pointer mod total.
  logic [PDATA_W-1:0] phase_totals [10] = '{
    32'd1024, 32'd40, 32'd2, 32'd700, 32'd1500, 32'd1, 32'd33, 32'd32, 32'd0, 32'd2047
  };

  // Predict one request: check the type bits, then scan the bitmap next-fit from
  // the pointer modulo the total. A free count that disagrees with the map ends
  // up in the full path, which clears the count and parks the pointer at 1 (0 at a total of 1).
  function automatic alloc_result_t predict_alloc(input logic [MODE_W-1:0] mode);
    alloc_result_t     res;
    logic [TYPE_W-1:0] kind;
    int unsigned       n;
    int unsigned       k;
    kind            = mode[MODE_W-1:PERM_BITS];
    res.status      = ST_FULL;
    res.entry_index = '0;
    if (kind != TYPE_REG && kind != TYPE_DIR && kind != TYPE_LNK) begin
      res.status    = ST_BAD_TYPE;
      res.free_left = tot_t'(free_cnt);
      return res;
    end
    if (free_cnt != 0) begin
      n = scan_ptr % total_cnt;
      for (k = 0; k < total_cnt; k++) begin
        if (!used_bits[n]) begin
          used_bits[n]    = 1'b1;
          free_cnt        = free_cnt - 1;
          scan_ptr        = n;
          res.status      = ST_OK;
          res.entry_index = idx_t'(n);
          res.free_left   = tot_t'(free_cnt);
          return res;
        end
        n = (n + 1) % total_cnt;
      end
    end
    free_cnt      = 0;
    scan_ptr      = 1 % total_cnt;
    res.free_left = '0;
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long; none in steady stretches.
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Wait until every queued request has been taken and answered, then pad.
  // Sample on the falling edge so the queues are stable.
  task automatic wait_drained(input int unsigned pad);
    while (queued_modes.size() != 0 || req_if.valid || predicted_allocs.size() != 0)
      @(negedge clk_i);
    repeat (pad) @(negedge clk_i);
  endtask

  // Setup then access cycle; the register takes the value at the access edge.
  // Mirror the clamp and the free-count reload; the bitmap stays as it is.
  task automatic write_entry_total(input logic [PDATA_W-1:0] value);
    int unsigned v;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ENTRY_TOTAL, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    v = value[TOT_W-1:0];
    total_cnt = (v == 0) ? 1 : ((v > MAX_ENTRIES) ? MAX_ENTRIES : v);
    free_cnt  = total_cnt;
    cfg_writes++;
  endtask

  // Request driver: predict at acceptance, hold the offer while stalled, then
  // idle for the chosen gap before offering the next mode word. At DRAIN_AT hold
  // off until the block has answered everything it owes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid      <= 1'b0;
      req_if.entry_mode <= '0;
      send_gap = 0;
    end else begin
      req_offer = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        predicted_allocs.push_back(predict_alloc(req_if.entry_mode));
        reqs_accepted++;
        req_offer = 1'b0;
      end
      if (!req_offer) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (queued_modes.size() != 0 &&
                     !(reqs_accepted == DRAIN_AT && predicted_allocs.size() != 0)) begin
          req_if.entry_mode <= queued_modes.pop_front();
          req_offer = 1'b1;
          send_gap  = pick_gap((reqs_accepted / 64) % 4 == 1);
        end
      end
      req_if.valid <= req_offer;
    end
  end

  // Result monitor: compare each accepted result with the oldest prediction and
  // drive ready with random stalls, plus one long hold-off that backs the block up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_stall = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (predicted_allocs.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: status %0d index %0d",
                                    rsp_if.status, rsp_if.entry_index));
        end else begin
          head_alloc = predicted_allocs.pop_front();
          if (rsp_if.status !== head_alloc.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d", results_checked,
                                      rsp_if.status, head_alloc.status));
          if (rsp_if.entry_index !== head_alloc.entry_index)
            report_mismatch($sformatf("result %0d entry_index %0d, want %0d", results_checked,
                                      rsp_if.entry_index, head_alloc.entry_index));
          if (rsp_if.free_left !== head_alloc.free_left)
            report_mismatch($sformatf("result %0d free_left %0d, want %0d", results_checked,
                                      rsp_if.free_left, head_alloc.free_left));
          case (head_alloc.status)
            ST_OK:       allocs_seen++;
            ST_BAD_TYPE: bad_type_seen++;
            default:     full_seen++;
          endcase
        end
        results_checked++;
      end
      if (results_checked == LONG_HOLD_AT && !long_hold_done) begin
        rsp_stall      = LONG_HOLD_LEN;
        long_hold_done = 1'b1;
      end
      rsp_accept = 1'b1;
      if (rsp_stall != 0) begin
        rsp_stall--;
        rsp_accept = 1'b0;
      end else if ((results_checked / 50) % 4 != 2 && $urandom_range(0, 3) == 0) begin
        rsp_stall  = pick_gap(1'b0);
        rsp_accept = (rsp_stall == 0);
      end
      rsp_if.ready <= rsp_accept;
    end
  end

  // Watchdog: end the run when no handshake of any kind happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] timeout: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned       i;
    int unsigned       p;
    logic [TYPE_W-1:0] kind;
    logic [PDATA_W-1:0] total_val;

    // Known values on every input before the first edge.
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_if.valid      = 1'b0;
    req_if.entry_mode = '0;
    rsp_if.ready      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Total of zero acts as one: allocate entry 0, then the free count runs out
    // and the pointer wraps to 1 mod 1; a bad type still reports the count.
    write_entry_total(32'd0);
    queued_modes.push_back({TYPE_REG, 9'h1A4});
    queued_modes.push_back({TYPE_DIR, 9'h1ED});
    queued_modes.push_back(16'h0000);
    wait_drained(4);

    // Five entries with entry 0 already taken: four allocations, then the count
    // disagrees with the map and the request comes back full.
    write_entry_total(32'd5);
    repeat (5) queued_modes.push_back({TYPE_LNK, 9'h1FF});
    wait_drained(4);

    // All-ones write: upper bits drop, 2047 clamps to the maximum.
    write_entry_total(32'hFFFF_FFFF);
    foreach (corner_modes[j]) queued_modes.push_back(corner_modes[j]);
    wait_drained(4);

    // Random phases: mostly valid types with random permissions, the rest noise.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      total_val = (p < 10) ? phase_totals[p] : PDATA_W'($urandom_range(0, 2047));
      write_entry_total(total_val);
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        case ($urandom_range(0, 3))
          0:       kind = TYPE_REG;
          1:       kind = TYPE_DIR;
          2:       kind = TYPE_LNK;
          default: kind = TYPE_W'($urandom);
        endcase
        queued_modes.push_back({kind, PERM_BITS'($urandom)});
      end
      wait_drained(4);
    end

    wait_drained(TAIL_CYCLES);
    $display("covered %0d requests over %0d entry_total writes", reqs_accepted, cfg_writes);
    $display("results: %0d allocated, %0d bad type, %0d full, %0d mismatches",
             allocs_seen, bad_type_seen, full_seen, mismatch_cnt);
    if (mismatch_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bnfa_pkg.sv
rtl/bnfa_if.sv
rtl/bnfa_apb.sv
rtl/bnfa_map.sv
rtl/bnfa_rem.sv
rtl/bnfa_ffz.sv
rtl/bitmap_next_fit_allocator_core.sv
sim/tb_bitmap_next_fit_allocator_core.sv
